>>> rtl/lbbs_pkg.sv
// Package with register codes, widths and the result type for the label bounding box block.
`timescale 1ns / 1ps
package lbbs_pkg;

  localparam int unsigned COORD_W = 13;
  localparam int unsigned LABEL_W = 8;
  localparam int unsigned REG_INDEX_W = 3;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [LABEL_W-1:0] label_t;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_MATCH_LABEL   = 3'd1,
    REG_WINDOW_LEFT   = 3'd2,
    REG_WINDOW_TOP    = 3'd3,
    REG_WINDOW_RIGHT  = 3'd4,
    REG_WINDOW_BOTTOM = 3'd5
  } reg_index_t;

  localparam coord_t IMAGE_WIDTH_RST   = 13'd640;
  localparam label_t MATCH_LABEL_RST   = 8'd1;
  localparam coord_t WINDOW_LEFT_RST   = 13'd0;
  localparam coord_t WINDOW_TOP_RST    = 13'd0;
  localparam coord_t WINDOW_RIGHT_RST  = 13'd640;
  localparam coord_t WINDOW_BOTTOM_RST = 13'd480;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
    logic   found;
  } box_t;

endpackage

>>> rtl/lbbs_if.sv
// Handshake interfaces for the pixel, box and configuration channels.
`timescale 1ns / 1ps
interface lbbs_pixel_if
  import lbbs_pkg::*;
();
  logic   valid;
  logic   ready;
  label_t pixel;
  logic   end_of_frame;

  modport source (output valid, output pixel, output end_of_frame, input ready);
  modport sink (input valid, input pixel, input end_of_frame, output ready);
endinterface

interface lbbs_box_if
  import lbbs_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t box_left;
  coord_t box_top;
  coord_t box_right;
  coord_t box_bottom;
  logic   found;

  modport source (output valid, output box_left, output box_top, output box_right,
                  output box_bottom, output found, input ready);
  modport sink (input valid, input box_left, input box_top, input box_right,
                input box_bottom, input found, output ready);
endinterface

interface lbbs_cfg_if
  import lbbs_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [REG_INDEX_W-1:0] reg_index;
  coord_t                 wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

>>> rtl/label_bounding_box_shrink.sv
// Streams a mask in raster order and reports the bounding box of one label in a window.
// The box request is registered: it appears in the cycle after the end-of-frame pixel is accepted.
// Throughput: one pixel per cycle; a pixel is taken while the box register is empty or
// being drained, so the box output register alone parts the two channels.
// Reset (rst, synchronous): registers return to their defaults, position and box clear.
// Configuration writes are taken every cycle and act from the next pixel.
`timescale 1ns / 1ps
module label_bounding_box_shrink
  import lbbs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input logic         clk,
  input logic         rst,
  lbbs_cfg_if.sink    cfg,
  lbbs_pixel_if.sink  pixels,
  lbbs_box_if.source  boxes
);

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
  localparam int unsigned WID_W  = ($clog2(MAX_WIDTH + 1) > COORD_W) ?
                                   $clog2(MAX_WIDTH + 1) : COORD_W;
  localparam int unsigned CCMP_W = (COL_W > COORD_W) ? COL_W : COORD_W;
  localparam int unsigned RCMP_W = (ROW_W > COORD_W) ? ROW_W : COORD_W;

  // configuration registers
  coord_t image_width;
  label_t match_label;
  coord_t window_left;
  coord_t window_top;
  coord_t window_right;
  coord_t window_bottom;

  // tracking state
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  coord_t           min_column;
  coord_t           max_column_end;
  coord_t           min_row;
  coord_t           max_row_end;
  logic             any_match;

  box_t result;
  logic result_valid;

  logic              accept;
  logic [WID_W-1:0]  eff_width;
  logic [WID_W-1:0]  col_step;
  logic [CCMP_W-1:0] col_x;
  logic [RCMP_W-1:0] row_x;
  logic              hit;
  coord_t            col_c;
  coord_t            row_c;
  box_t              box_next;

  assign cfg.ready    = 1'b1;
  assign pixels.ready = !result_valid || boxes.ready;
  assign accept       = pixels.valid && pixels.ready;

  always_comb begin
    if (image_width == '0) begin
      eff_width = WID_W'(1);
    end else if (WID_W'(image_width) > WID_W'(MAX_WIDTH)) begin
      eff_width = WID_W'(MAX_WIDTH);
    end else begin
      eff_width = WID_W'(image_width);
    end
  end

  assign col_step = WID_W'(column_count) + WID_W'(1);
  assign col_x    = CCMP_W'(column_count);
  assign row_x    = RCMP_W'(row_count);

  // a matching position lies below the 13-bit window end, so it fits in 13 bits
  assign col_c = col_x[COORD_W-1:0];
  assign row_c = row_x[COORD_W-1:0];

  assign hit = (pixels.pixel == match_label) &&
               (col_x >= CCMP_W'(window_left)) && (col_x < CCMP_W'(window_right)) &&
               (row_x >= RCMP_W'(window_top)) && (row_x < RCMP_W'(window_bottom));

  always_comb begin
    box_next.left   = min_column;
    box_next.top    = min_row;
    box_next.right  = max_column_end;
    box_next.bottom = max_row_end;
    box_next.found  = any_match;
    if (hit) begin
      if (!any_match || col_c < min_column) begin
        box_next.left = col_c;
      end
      if (!any_match || (col_c + 13'd1) > max_column_end) begin
        box_next.right = col_c + 13'd1;
      end
      if (!any_match || row_c < min_row) begin
        box_next.top = row_c;
      end
      if (!any_match || (row_c + 13'd1) > max_row_end) begin
        box_next.bottom = row_c + 13'd1;
      end
      box_next.found = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= IMAGE_WIDTH_RST;
      match_label   <= MATCH_LABEL_RST;
      window_left   <= WINDOW_LEFT_RST;
      window_top    <= WINDOW_TOP_RST;
      window_right  <= WINDOW_RIGHT_RST;
      window_bottom <= WINDOW_BOTTOM_RST;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg.wdata;
        REG_MATCH_LABEL:   match_label   <= cfg.wdata[LABEL_W-1:0];
        REG_WINDOW_LEFT:   window_left   <= cfg.wdata;
        REG_WINDOW_TOP:    window_top    <= cfg.wdata;
        REG_WINDOW_RIGHT:  window_right  <= cfg.wdata;
        REG_WINDOW_BOTTOM: window_bottom <= cfg.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= '0;
      row_count      <= '0;
      min_column     <= '0;
      max_column_end <= '0;
      min_row        <= '0;
      max_row_end    <= '0;
      any_match      <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (accept && pixels.end_of_frame) begin
        result_valid <= 1'b1;
      end else if (boxes.ready) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        if (pixels.end_of_frame) begin
          result         <= box_next;
          column_count   <= '0;
          row_count      <= '0;
          min_column     <= '0;
          max_column_end <= '0;
          min_row        <= '0;
          max_row_end    <= '0;
          any_match      <= 1'b0;
        end else begin
          min_column     <= box_next.left;
          max_column_end <= box_next.right;
          min_row        <= box_next.top;
          max_row_end    <= box_next.bottom;
          any_match      <= box_next.found;
          if (col_step >= eff_width) begin
            column_count <= '0;
            // hold the last row once the row position saturates
            if (row_count != ROW_W'(MAX_HEIGHT - 1)) begin
              row_count <= row_count + ROW_W'(1);
            end
          end else begin
            column_count <= col_step[COL_W-1:0];
          end
        end
      end
    end
  end

  assign boxes.valid      = result_valid;
  assign boxes.box_left   = result.left;
  assign boxes.box_top    = result.top;
  assign boxes.box_right  = result.right;
  assign boxes.box_bottom = result.bottom;
  assign boxes.found      = result.found;

endmodule

>>> tb/tb_top.sv
// Self-checking bench for the label bounding box block: directed and random frames.
`timescale 1ns / 1ps
module tb_top;
  import lbbs_pkg::*;

  localparam int unsigned MAX_COLS      = 4096;
  localparam int unsigned MAX_ROWS      = 4096;
  localparam int unsigned RANDOM_PIXELS = 850;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_PHASE    = 2;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam logic [REG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam coord_t COORD_MAX = 13'h1FFF;

  typedef struct {
    label_t value;
    logic   frame_end;
  } pixel_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lbbs_cfg_if   cfg_bus ();
  lbbs_pixel_if pix_bus ();
  lbbs_box_if   box_bus ();

  label_bounding_box_shrink #(
    .MAX_WIDTH  (MAX_COLS),
    .MAX_HEIGHT (MAX_ROWS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .pixels (pix_bus),
    .boxes  (box_bus)
  );

  pixel_req_t  pixel_queue[$];
  box_t        box_expected[$];

  // predictor copy of the registers and of the tracking state
  coord_t      width_reg, left_reg, top_reg, right_reg, bottom_reg;
  label_t      label_reg;
  coord_t      col_pos, row_pos, min_col, col_end, min_row, row_end;
  logic        seen;

  logic        px_taken = 1'b0;
  logic        quiet = 1'b0;
  logic        long_hold = 1'b0;
  int unsigned send_gap, sink_stall, mismatches, cycles, phase_no;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned row_length(coord_t w);
    if (w == 0) return 1;
    if (w > MAX_COLS) return MAX_COLS;
    return 32'(w);
  endfunction

  task automatic clear_tracking();
    col_pos = '0;
    row_pos = '0;
    min_col = '0;
    col_end = '0;
    min_row = '0;
    row_end = '0;
    seen    = 1'b0;
  endtask

  task automatic track_pixel(label_t value, logic frame_end);
    int unsigned col;
    int unsigned row;
    box_t        box;
    col = 32'(col_pos);
    row = 32'(row_pos);
    if (value == label_reg && col >= left_reg && col < right_reg &&
        row >= top_reg && row < bottom_reg) begin
      if (!seen || col < min_col) min_col = coord_t'(col);
      if (!seen || col + 1 > col_end) col_end = coord_t'(col + 1);
      if (!seen || row < min_row) min_row = coord_t'(row);
      if (!seen || row + 1 > row_end) row_end = coord_t'(row + 1);
      seen = 1'b1;
    end
    if (frame_end) begin
      box = '0;
      if (seen) begin
        box.left   = min_col;
        box.top    = min_row;
        box.right  = col_end;
        box.bottom = row_end;
        box.found  = 1'b1;
      end
      box_expected.push_back(box);
      clear_tracking();
    end else if (col + 1 >= row_length(width_reg)) begin
      col_pos = '0;
      // saturate in the last row
      if (row + 1 < MAX_ROWS) row_pos = coord_t'(row + 1);
    end else begin
      col_pos = coord_t'(col + 1);
    end
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = IMAGE_WIDTH_RST;
      label_reg  = MATCH_LABEL_RST;
      left_reg   = WINDOW_LEFT_RST;
      top_reg    = WINDOW_TOP_RST;
      right_reg  = WINDOW_RIGHT_RST;
      bottom_reg = WINDOW_BOTTOM_RST;
      clear_tracking();
      px_taken = 1'b0;
    end else begin
      // a pixel taken at this edge still sees the old registers
      px_taken = pix_bus.valid && pix_bus.ready;
      if (px_taken) track_pixel(pix_bus.pixel, pix_bus.end_of_frame);
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.reg_index)
          REG_IMAGE_WIDTH:   width_reg = cfg_bus.wdata;
          REG_MATCH_LABEL:   label_reg = cfg_bus.wdata[LABEL_W-1:0];
          REG_WINDOW_LEFT:   left_reg = cfg_bus.wdata;
          REG_WINDOW_TOP:    top_reg = cfg_bus.wdata;
          REG_WINDOW_RIGHT:  right_reg = cfg_bus.wdata;
          REG_WINDOW_BOTTOM: bottom_reg = cfg_bus.wdata;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin : box_check
    box_t want;
    if (!rst && box_bus.valid && box_bus.ready) begin
      if (box_expected.size() == 0) begin
        report_mismatch("box with none pending", 1, 0);
      end else begin
        want = box_expected.pop_front();
        if (box_bus.box_left !== want.left)
          report_mismatch("box_left", 32'(box_bus.box_left), 32'(want.left));
        if (box_bus.box_top !== want.top)
          report_mismatch("box_top", 32'(box_bus.box_top), 32'(want.top));
        if (box_bus.box_right !== want.right)
          report_mismatch("box_right", 32'(box_bus.box_right), 32'(want.right));
        if (box_bus.box_bottom !== want.bottom)
          report_mismatch("box_bottom", 32'(box_bus.box_bottom), 32'(want.bottom));
        if (box_bus.found !== want.found)
          report_mismatch("found", 32'(box_bus.found), 32'(want.found));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL label_bounding_box_shrink");
      $finish;
    end
  end

  // pixel driver: hold the request until taken, then advance after a random gap
  always @(negedge clk) begin : pixel_driver
    pixel_req_t req;
    if (rst) begin
      pix_bus.valid <= 1'b0;
    end else if (!pix_bus.valid || px_taken) begin
      if (send_gap != 0) begin
        send_gap--;
        pix_bus.valid <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        req = pixel_queue.pop_front();
        pix_bus.valid        <= 1'b1;
        pix_bus.pixel        <= req.value;
        pix_bus.end_of_frame <= req.frame_end;
        send_gap = pick_gap();
      end else begin
        pix_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst || long_hold) begin
      box_bus.ready <= 1'b0;
    end else if (sink_stall != 0) begin
      sink_stall--;
      box_bus.ready <= 1'b0;
    end else begin
      box_bus.ready <= 1'b1;
      sink_stall = pick_gap();
    end
  end

  // back-pressure long enough for a held box to stall the pixel input
  initial begin : receiver_hold
    wait (phase_no == HOLD_PHASE);
    long_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    long_hold = 1'b0;
  end

  task automatic push_pixel(label_t value, logic frame_end);
    pixel_req_t req;
    req.value     = value;
    req.frame_end = frame_end;
    pixel_queue.push_back(req);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pixel_queue.size() != 0 || pix_bus.valid || box_expected.size() != 0);
    // let a last pixel without a box settle in the block
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // call at a falling edge; leaves valid high for a following write
  task automatic write_reg(logic [REG_INDEX_W-1:0] index, coord_t value);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= index;
    cfg_bus.wdata     <= value;
    do @(posedge clk);
    while (!cfg_bus.ready);
    @(negedge clk);
  endtask

  task automatic setup(coord_t w, label_t lab, coord_t l, coord_t t, coord_t r, coord_t b);
    coord_t label_word;
    label_word = coord_t'($urandom);
    label_word[LABEL_W-1:0] = lab;
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_MATCH_LABEL, label_word);
    write_reg(REG_WINDOW_LEFT, l);
    write_reg(REG_WINDOW_TOP, t);
    write_reg(REG_WINDOW_RIGHT, r);
    write_reg(REG_WINDOW_BOTTOM, b);
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, coord_t'($urandom));
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned random_count;
    int unsigned ew, w, l, t, r, b, n, nf, sel;
    label_t      lab;
    logic        partial;

    cfg_bus.valid        = 1'b0;
    cfg_bus.reg_index    = REG_IMAGE_WIDTH;
    cfg_bus.wdata        = '0;
    random_count         = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // reset settings: label 1 over the whole default window
    push_pixel(8'd1, 1'b1);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b1);
    wait_idle();

    // window over the lower-right 2x2 of a 3x3 image, reaching its right and bottom edges
    setup(13'd3, 8'd255, 13'd1, 13'd1, 13'd3, 13'd3);
    for (int i = 0; i < 9; i++) push_pixel(8'd255, i == 8);
    wait_idle();

    // empty window: right equal to left
    setup(13'd4, 8'd0, 13'd2, 13'd0, 13'd2, 13'd8);
    for (int i = 0; i < 4; i++) push_pixel(8'd0, i == 3);
    wait_idle();

    // window reaching far beyond the image
    setup(13'd3, 8'd7, 13'd0, 13'd0, COORD_MAX, COORD_MAX);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd7, 1'b0);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd7, 1'b1);
    wait_idle();

    // shrink the width mid-frame below the current column
    setup(13'd10, 8'd5, 13'd0, 13'd0, COORD_MAX, COORD_MAX);
    for (int i = 0; i < 5; i++) push_pixel(8'd5, 1'b0);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 13'd2);
    cfg_bus.valid <= 1'b0;
    for (int i = 0; i < 3; i++) push_pixel(8'd5, i == 2);
    wait_idle();

    while (random_count < RANDOM_PIXELS) begin
      phase_no++;
      quiet = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 19);
      if (sel == 0) w = 0;
      else if (sel == 1) w = MAX_COLS;
      else if (sel == 2) w = $urandom_range(MAX_COLS + 1, COORD_MAX);
      else if (sel < 15) w = $urandom_range(1, 8);
      else w = $urandom_range(9, 40);
      ew = row_length(coord_t'(w));
      lab = label_t'($urandom);

      sel = $urandom_range(0, 7);
      if (sel == 0) begin
        // empty window, in columns or in rows
        if ($urandom_range(0, 1)) begin
          l = $urandom_range(0, ew);
          r = $urandom_range(0, l);
          t = 0;
          b = COORD_MAX;
        end else begin
          l = 0;
          r = COORD_MAX;
          t = $urandom_range(0, 8);
          b = $urandom_range(0, t);
        end
      end else if (sel == 1) begin
        l = $urandom_range(0, ew);
        r = $urandom_range(l, COORD_MAX);
        t = $urandom_range(0, 4);
        b = $urandom_range(t, COORD_MAX);
      end else if (sel == 2) begin
        l = $urandom_range(0, COORD_MAX);
        t = $urandom_range(0, COORD_MAX);
        r = COORD_MAX;
        b = COORD_MAX;
      end else begin
        l = $urandom_range(0, ew - 1);
        r = $urandom_range(l + 1, ew + 1);
        t = $urandom_range(0, 3);
        b = $urandom_range(t + 1, 8);
      end
      setup(coord_t'(w), lab, coord_t'(l), coord_t'(t), coord_t'(r), coord_t'(b));

      nf = (phase_no == HOLD_PHASE) ? 4 : $urandom_range(1, 4);
      for (int f = 0; f < nf; f++) begin
        if (ew <= 40) n = $urandom_range(1, (ew * 6 > 60) ? 60 : ew * 6);
        else n = $urandom_range(1, 30);
        // leave some phases mid-frame so the next writes land inside a frame
        partial = (f == nf - 1) && (phase_no != HOLD_PHASE) && ($urandom_range(0, 4) == 0);
        for (int i = 0; i < n; i++)
          push_pixel(($urandom_range(0, 9) < 4) ? lab : label_t'($urandom),
                     !partial && (i == n - 1));
        random_count += n;
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("PASS label_bounding_box_shrink");
    end else begin
      $display("FAIL label_bounding_box_shrink");
    end
    $finish;
  end

endmodule
